// File: src/csbr_pkg.sv
// shared types, register codes and digit helpers for the clock set button repeat block
package csbr_pkg;

   // configuration register indexes
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 10;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_REPEAT_INTERVAL  = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_DISPLAY_PERIOD   = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_MEDIUM_THRESHOLD = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_FAST_THRESHOLD   = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_SLOW_STEP        = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_MEDIUM_STEP      = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_FAST_STEP        = 3'd6;

   // reset values of the registers
   localparam logic [9:0] RESET_REPEAT_INTERVAL  = 10'd250;
   localparam logic [9:0] RESET_DISPLAY_PERIOD   = 10'd200;
   localparam logic [7:0] RESET_MEDIUM_THRESHOLD = 8'd5;
   localparam logic [7:0] RESET_FAST_THRESHOLD   = 8'd10;
   localparam logic [5:0] RESET_SLOW_STEP        = 6'd1;
   localparam logic [5:0] RESET_MEDIUM_STEP      = 6'd5;
   localparam logic [5:0] RESET_FAST_STEP        = 6'd20;

   // time constants
   localparam logic [10:0] SINCE_MAX     = 11'd2047;
   localparam logic [6:0]  MINUTES_HOUR  = 7'd60;
   localparam logic [6:0]  TWO_HOURS_MIN = 7'd120;
   localparam logic [5:0]  HOURS_DAY     = 6'd24;
   localparam logic [4:0]  LAST_HOUR     = 5'd23;

   typedef struct packed {
      logic [9:0] repeat_interval;
      logic [9:0] display_period;
      logic [7:0] medium_threshold;
      logic [7:0] fast_threshold;
      logic [5:0] slow_step;
      logic [5:0] medium_step;
      logic [5:0] fast_step;
   } cfg_type;

   typedef struct packed {
      logic       up_pressed;
      logic       down_pressed;
      logic [4:0] clock_hour;
      logic [5:0] clock_minute;
   } req_type;

   typedef struct packed {
      logic       set_time;
      logic [4:0] new_hour;
      logic [5:0] new_minute;
      logic       show;
      logic [1:0] hour_tens;
      logic [3:0] hour_ones;
      logic [2:0] minute_tens;
      logic [3:0] minute_ones;
   } rsp_type;

   // fixed-width part of the block state
   typedef struct packed {
      logic        idle;
      logic [10:0] since_action;
      logic [9:0]  display_count;
   } state_type;

   // tens digit of a value below 64 by a compare chain
   function automatic logic [2:0] tens_of(input logic [5:0] value);
      logic [2:0] tens;
      tens = 3'd0;
      for (int i = 1; i <= 6; i++) begin
         if (value >= 6'(i * 10)) begin
            tens = 3'(i);
         end
      end
      return tens;
   endfunction

   // ones digit given the tens digit
   function automatic logic [3:0] ones_of(input logic [5:0] value, input logic [2:0] tens);
      logic [5:0] sub;
      sub = {tens, 3'b000} + {2'b00, tens, 1'b0};
      return 4'(value - sub);
   endfunction

endpackage

// File: src/csbr_csr.sv
// configuration register file of the clock set button repeat block
module csbr_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [csbr_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [csbr_pkg::CSR_DATA_WIDTH-1:0]   csr_data,
   output csbr_pkg::cfg_type                     cfg
);
   import csbr_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // decode one register write
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_REPEAT_INTERVAL:  cfg_in.repeat_interval  = csr_data[9:0];
            REG_DISPLAY_PERIOD:   cfg_in.display_period   = csr_data[9:0];
            REG_MEDIUM_THRESHOLD: cfg_in.medium_threshold = csr_data[7:0];
            REG_FAST_THRESHOLD:   cfg_in.fast_threshold   = csr_data[7:0];
            REG_SLOW_STEP:        cfg_in.slow_step        = csr_data[5:0];
            REG_MEDIUM_STEP:      cfg_in.medium_step      = csr_data[5:0];
            REG_FAST_STEP:        cfg_in.fast_step        = csr_data[5:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.repeat_interval  <= RESET_REPEAT_INTERVAL;
         cfg_ff.display_period   <= RESET_DISPLAY_PERIOD;
         cfg_ff.medium_threshold <= RESET_MEDIUM_THRESHOLD;
         cfg_ff.fast_threshold   <= RESET_FAST_THRESHOLD;
         cfg_ff.slow_step        <= RESET_SLOW_STEP;
         cfg_ff.medium_step      <= RESET_MEDIUM_STEP;
         cfg_ff.fast_step        <= RESET_FAST_STEP;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: src/csbr_core.sv
// combinational time adjust and display digit logic for one item
module csbr_core #(
   parameter int HOLD_COUNT_WIDTH = 16
) (
   input  csbr_pkg::cfg_type              cfg,
   input  csbr_pkg::req_type              item,
   input  csbr_pkg::state_type            state,
   input  logic [HOLD_COUNT_WIDTH-1:0]    hold_count,
   output csbr_pkg::rsp_type              result,
   output csbr_pkg::state_type            state_next,
   output logic [HOLD_COUNT_WIDTH-1:0]    hold_count_next
);
   import csbr_pkg::*;

   localparam int CMP_WIDTH = (HOLD_COUNT_WIDTH > 8) ? HOLD_COUNT_WIDTH : 8;

   logic [CMP_WIDTH-1:0] hold_ext;
   logic [CMP_WIDTH-1:0] medium_ext;
   logic [CMP_WIDTH-1:0] fast_ext;
   logic [5:0]           step;
   logic [6:0]           sum;
   logic [6:0]           deficit;
   logic                 borrow;
   logic [5:0]           hour_up;
   logic [4:0]           hour_u;
   logic [5:0]           min_u;
   logic [4:0]           hour_d;
   logic [5:0]           min_d;
   logic [10:0]          elapsed;
   logic                 act;
   logic                 pressed;
   logic [9:0]           period;
   logic [10:0]          disp_inc;
   logic [2:0]           h_tens;
   logic [2:0]           m_tens;

   // step size from the hold count before this action
   assign hold_ext   = CMP_WIDTH'(hold_count);
   assign medium_ext = CMP_WIDTH'(cfg.medium_threshold);
   assign fast_ext   = CMP_WIDTH'(cfg.fast_threshold);

   always_comb begin
      if (hold_ext > fast_ext) begin
         step = cfg.fast_step;
      end else if (hold_ext > medium_ext) begin
         step = cfg.medium_step;
      end else begin
         step = cfg.slow_step;
      end
   end

   // up: carry into the hour, wrap the day
   assign sum     = {1'b0, item.clock_minute} + {1'b0, step};
   assign hour_up = {1'b0, item.clock_hour} + {5'd0, (sum >= MINUTES_HOUR)};

   always_comb begin
      if (sum >= TWO_HOURS_MIN) begin
         min_u = 6'(sum - TWO_HOURS_MIN);
      end else if (sum >= MINUTES_HOUR) begin
         min_u = 6'(sum - MINUTES_HOUR);
      end else begin
         min_u = sum[5:0];
      end
      hour_u = (hour_up >= HOURS_DAY) ? 5'd0 : hour_up[4:0];
   end

   // down: borrow from the hour, one extra wrap for a large step
   assign borrow  = item.clock_minute < step;
   assign deficit = {1'b0, step} - {1'b0, item.clock_minute};

   always_comb begin
      if (!borrow) begin
         min_d  = item.clock_minute - step;
         hour_d = item.clock_hour;
      end else begin
         if (deficit > MINUTES_HOUR) begin
            min_d = 6'(TWO_HOURS_MIN - deficit);
         end else begin
            min_d = 6'(MINUTES_HOUR - deficit);
         end
         hour_d = (item.clock_hour == 5'd0) ? LAST_HOUR : item.clock_hour - 5'd1;
      end
   end

   // repeat timing
   assign elapsed = (state.since_action == SINCE_MAX) ? SINCE_MAX : state.since_action + 11'd1;
   assign act     = state.idle || (elapsed > {1'b0, cfg.repeat_interval});
   assign pressed = item.up_pressed || item.down_pressed;

   // display period counter, zero period acts as one
   assign period   = (cfg.display_period == 10'd0) ? 10'd1 : cfg.display_period;
   assign disp_inc = {1'b0, state.display_count} + 11'd1;
   assign h_tens   = tens_of({1'b0, item.clock_hour});
   assign m_tens   = tens_of(item.clock_minute);

   always_comb begin
      result     = '0;
      state_next = state;
      hold_count_next = hold_count;

      // display digits of the input time
      if (state.display_count == 10'd0) begin
         result.show        = 1'b1;
         result.hour_tens   = h_tens[1:0];
         result.hour_ones   = ones_of({1'b0, item.clock_hour}, h_tens);
         result.minute_tens = m_tens;
         result.minute_ones = ones_of(item.clock_minute, m_tens);
      end
      state_next.display_count = (disp_inc >= {1'b0, period}) ? 10'd0 : disp_inc[9:0];

      // button action
      if (act) begin
         state_next.since_action = 11'd0;
         if (pressed) begin
            result.set_time = 1'b1;
            if (item.up_pressed) begin
               result.new_hour   = hour_u;
               result.new_minute = min_u;
            end else begin
               result.new_hour   = hour_d;
               result.new_minute = min_d;
            end
            if (hold_count != '1) begin
               hold_count_next = hold_count + HOLD_COUNT_WIDTH'(1);
            end
            state_next.idle = 1'b0;
         end else begin
            hold_count_next = '0;
            state_next.idle = 1'b1;
         end
      end else begin
         state_next.since_action = elapsed;
      end
   end

endmodule

// File: src/clock_set_button_repeat_unit.sv
// top level of the clock set button repeat block: item registers, state and handshakes
//
// Usage: one item per millisecond tick enters on the req_ channel (req_valid, req_stall,
// req_data) with the up and down button levels and the time read from the counter.
// Every item yields exactly one result item on the rsp_ channel (rsp_valid, rsp_stall,
// rsp_data): a write-back request with the stepped time when a button action is due,
// and every display_period items the four decimal digits of the input time.
// Each item passes through the input register and then the result register.
// Throughput is one item per cycle while rsp_stall is low; the step logic is a single
// pass between the two registers, and the input register can take one more item while
// a result waits. When rsp_stall is high the result holds; once the input register is
// also full, req_stall rises until the result is taken.
// Registers are written on the csr_ port (csr_valid, csr_ready, csr_index, csr_data),
// always ready; the user must write them only while no item is in flight (unenforced).
// Synchronous reset restores the register defaults, sets the block idle with zero hold
// and elapsed counts and empties both item registers.
module clock_set_button_repeat_unit #(
   parameter int HOLD_COUNT_WIDTH = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  csbr_pkg::req_type                     req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output csbr_pkg::rsp_type                     rsp_data,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [csbr_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [csbr_pkg::CSR_DATA_WIDTH-1:0]   csr_data
);
   import csbr_pkg::*;

   cfg_type                      cfg;
   logic                         in_valid_ff;
   req_type                      in_data_ff;
   logic                         out_valid_ff;
   logic                         out_valid_in;
   rsp_type                      out_data_ff;
   state_type                    state_ff;
   state_type                    state_in;
   logic [HOLD_COUNT_WIDTH-1:0]  hold_ff;
   logic [HOLD_COUNT_WIDTH-1:0]  hold_in;
   rsp_type                      result;
   logic                         out_free;
   logic                         advance;
   logic                         take;

   csbr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   csbr_core #(
      .HOLD_COUNT_WIDTH (HOLD_COUNT_WIDTH)
   ) u_core (
      .cfg             (cfg),
      .item            (in_data_ff),
      .state           (state_ff),
      .hold_count      (hold_ff),
      .result          (result),
      .state_next      (state_in),
      .hold_count_next (hold_in)
   );

   // handshake control
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign take      = req_valid && !req_stall;
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '{idle: 1'b1, since_action: '0, display_count: '0};
         hold_ff      <= '0;
      end else begin
         if (take || advance) begin
            in_valid_ff <= take;
         end
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_in;
            hold_ff  <= hold_in;
         end
      end
   end

   // item payload registers
   always_ff @(posedge clock) begin
      if (take) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= result;
      end
   end

   // a stall is only raised with a full input register
   assert property (@(posedge clock) disable iff (reset) req_stall |-> in_valid_ff)
      else $error("input stall without a held item");

   // idle always goes with a cleared hold count
   assert property (@(posedge clock) disable iff (reset) state_ff.idle |-> (hold_ff == '0))
      else $error("idle with nonzero hold count");

   // an issued write-back restarts the repeat timer and leaves idle
   assert property (@(posedge clock) disable iff (reset)
      (advance && result.set_time) |=> (!state_ff.idle && state_ff.since_action == 11'd0))
      else $error("write-back did not restart the repeat timer");

   // results without a write-back or display carry zero fields
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_data_ff.set_time) |->
      (out_data_ff.new_hour == 5'd0 && out_data_ff.new_minute == 6'd0))
      else $error("time fields set without a write-back");

   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_data_ff.show) |->
      (out_data_ff.hour_tens == 2'd0 && out_data_ff.hour_ones == 4'd0 &&
       out_data_ff.minute_tens == 3'd0 && out_data_ff.minute_ones == 4'd0))
      else $error("digits set without a display update");

endmodule
